@@ sv/mtcr_pkg.sv @@
// Package for the monochrome text cell row renderer.
// Holds widths, font geometry, register indexes and the shared structs.
// No dependencies.
package mtcr_pkg;

  localparam int unsigned FONT_DEPTH = 8192;
  localparam int unsigned CELL_WIDTH = 9;
  localparam int unsigned FontAw = $clog2(FONT_DEPTH);

  localparam logic [7:0] AttrColorMask = 8'b0111_0111;
  localparam logic [7:0] AttrReverse   = 8'b0111_0000;
  localparam logic [2:0] AttrUnderline = 3'b001;
  localparam logic [2:0] FgFull        = 3'b111;
  localparam logic [2:0] LineGfxTop    = 3'b110;
  localparam logic [3:0] BgBright      = 4'hF;

  typedef enum logic [2:0] {
    RegCharHeight  = 3'd0,
    RegCursorStart = 3'd1,
    RegCursorEnd   = 3'd2,
    RegCursorMode  = 3'd3,
    RegCursorAddr  = 3'd4,
    RegBlinkEnable = 3'd5,
    RegVideoEnable = 3'd6
  } reg_index_e;

  typedef enum logic [1:0] {
    CursorOff  = 2'd0,
    CursorFast = 2'd1,
    CursorSlow = 2'd2
  } cursor_mode_e;

  typedef struct packed {
    logic [4:0]  char_height;
    logic [4:0]  cursor_start;
    logic [4:0]  cursor_end;
    logic [1:0]  cursor_mode;
    logic [13:0] cursor_address;
    logic        blink_enable;
    logic        video_enable;
  } cfg_t;

  typedef struct packed {
    logic       drawn;
    logic       show;
    logic       cursor_line;
    logic       uline;
    logic       line_gfx;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
  } row_ctrl_t;

endpackage

@@ sv/mtcr_cfg_regs.sv @@
// Configuration register file of the text cell row renderer.
// Depends on mtcr_pkg for the register indexes and cfg_t.
module mtcr_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [13:0]       cfg_wdata_i,
  output mtcr_pkg::cfg_t    cfg_o
);
  import mtcr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        RegCharHeight:  cfg_d.char_height    = cfg_wdata_i[4:0];
        RegCursorStart: cfg_d.cursor_start   = cfg_wdata_i[4:0];
        RegCursorEnd:   cfg_d.cursor_end     = cfg_wdata_i[4:0];
        RegCursorMode:  cfg_d.cursor_mode    = cfg_wdata_i[1:0];
        RegCursorAddr:  cfg_d.cursor_address = cfg_wdata_i;
        RegBlinkEnable: cfg_d.blink_enable   = cfg_wdata_i[0];
        RegVideoEnable: cfg_d.video_enable   = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.char_height    <= 5'd14;
      cfg_q.cursor_start   <= 5'd11;
      cfg_q.cursor_end     <= 5'd12;
      cfg_q.cursor_mode    <= CursorOff;
      cfg_q.cursor_address <= '0;
      cfg_q.blink_enable   <= 1'b0;
      cfg_q.video_enable   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/mtcr_attr_decode.sv @@
// Attribute, cursor and underline decode for one render beat.
// Depends on mtcr_pkg for cfg_t, row_ctrl_t and attribute constants.
module mtcr_attr_decode (
  input  mtcr_pkg::cfg_t      cfg_i,
  input  logic                action_i,
  input  logic [7:0]          char_code_i,
  input  logic [7:0]          attribute_i,
  input  logic [3:0]          row_i,
  input  logic [10:0]         cell_address_i,
  input  logic                blink_fast_i,
  input  logic                blink_slow_i,
  input  logic                in_display_i,
  output mtcr_pkg::row_ctrl_t ctrl_o
);
  import mtcr_pkg::*;

  logic       char_blink;
  logic       reverse;
  logic       color_set;
  logic       phase_ok;
  logic       is_cursor;
  logic [4:0] row_w;
  logic [4:0] last_line;

  always_comb begin
    row_w      = {1'b0, row_i};
    last_line  = cfg_i.char_height - 5'd1;
    char_blink = cfg_i.blink_enable & attribute_i[7];
    color_set  = (attribute_i & AttrColorMask) != 8'h00;
    reverse    = (attribute_i & AttrColorMask) == AttrReverse;

    unique case (cursor_mode_e'(cfg_i.cursor_mode))
      CursorFast: phase_ok = blink_fast_i;
      CursorSlow: phase_ok = blink_slow_i;
      default:    phase_ok = 1'b0;
    endcase
    is_cursor = phase_ok && (cfg_i.cursor_address[13:11] == 3'b000)
                && (cell_address_i == cfg_i.cursor_address[10:0]);

    ctrl_o.drawn       = action_i & cfg_i.video_enable & in_display_i;
    ctrl_o.show        = ~char_blink | blink_fast_i;
    ctrl_o.cursor_line = is_cursor && (row_w >= cfg_i.cursor_start)
                         && (row_w <= cfg_i.cursor_end);
    ctrl_o.uline       = ctrl_o.show && (attribute_i[2:0] == AttrUnderline)
                         && (cfg_i.char_height != 5'd0) && (row_w == last_line);
    ctrl_o.line_gfx    = char_code_i[7:5] == LineGfxTop;
    if (!color_set) begin
      ctrl_o.fg_index = 4'h0;
    end else if (reverse) begin
      ctrl_o.fg_index = {attribute_i[3], 3'b000};
    end else begin
      ctrl_o.fg_index = {attribute_i[3], FgFull};
    end
    ctrl_o.bg_index = (reverse || (!cfg_i.blink_enable && attribute_i[7])) ? BgBright : 4'h0;
  end

endmodule

@@ sv/mtcr_font_mem.sv @@
// Font store: single-port synchronous RAM, one write or one read per cycle.
// Read data is registered and held until the next read. Depends on mtcr_pkg.
module mtcr_font_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic                      re_i,
  input  logic [mtcr_pkg::FontAw-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);
  import mtcr_pkg::*;

  logic [7:0] mem [FONT_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mtcr_dot_gen.sv @@
// Dot row builder: expands a font byte into the nine dots of a cell row.
// Depends on mtcr_pkg for row_ctrl_t and CELL_WIDTH.
module mtcr_dot_gen (
  input  mtcr_pkg::row_ctrl_t ctrl_i,
  input  logic [7:0]          glyph_i,
  input  logic                last_dot_i,
  output logic [8:0]          dots_o,
  output logic                last_dot_o
);
  import mtcr_pkg::*;

  logic [CELL_WIDTH-1:0] raw;
  logic                  fill;

  always_comb begin
    for (int x = 0; x < 8; x++) begin
      raw[x] = ctrl_i.show & glyph_i[7-x];
    end
    raw[CELL_WIDTH-1] = ctrl_i.line_gfx & raw[7];
    fill = ctrl_i.cursor_line | ctrl_i.uline;
    if (ctrl_i.drawn) begin
      dots_o     = raw | {CELL_WIDTH{fill}};
      last_dot_o = raw[CELL_WIDTH-1];
    end else begin
      dots_o     = '0;
      last_dot_o = last_dot_i;
    end
  end

endmodule

@@ sv/mono_text_cell_row_renderer.sv @@
// Top level of the monochrome text cell row renderer.
// Depends on mtcr_pkg, mtcr_cfg_regs, mtcr_attr_decode, mtcr_font_mem, mtcr_dot_gen.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one beat per item. action 0 writes
//   font_data_i into the font store at font_address_i (ignored at or beyond
//   the store depth); action 1 renders one row of one character cell.
//   Output channel (out_valid_o/out_ready_i): exactly one beat per input beat,
//   in order. Load beats and rows that are not drawn give zero dots and
//   indices, with status_dot repeating the held last dot.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at
//   the clock edge; write only while no beat is in flight.
//   Pipeline: the font RAM is read and the decoded controls are registered at
//   the accepting edge; the dots are registered when the read stage advances.
//   Throughput: one item per cycle while out_ready_i is high; the single font
//   RAM port serves at most one write or one read per item.
//   Reset: registers return to their defaults, last dot clears, pipeline
//   empties. The font store is not cleared and must be loaded before use.
//   Stall: while out_ready_i is low the output beat holds, the read stage
//   fills, and in_ready_o drops once both are occupied.
module mono_text_cell_row_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [12:0] font_address_i,
  input  logic [7:0]  font_data_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  attribute_i,
  input  logic [3:0]  row_i,
  input  logic [10:0] cell_address_i,
  input  logic        blink_fast_i,
  input  logic        blink_slow_i,
  input  logic        in_display_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drawn_o,
  output logic [8:0]  dots_o,
  output logic [3:0]  fg_index_o,
  output logic [3:0]  bg_index_o,
  output logic        status_dot_o
);
  import mtcr_pkg::*;

  cfg_t       cfg;
  row_ctrl_t  ctrl_dec;
  row_ctrl_t  ctrl_q;
  logic       s1_valid_q;
  logic       s1_adv;
  logic       accept;
  logic       mem_we;
  logic       mem_re;
  logic [FontAw-1:0] mem_addr;
  logic [7:0] glyph;
  logic [8:0] dots_d;
  logic       last_dot_d, last_dot_q;
  logic       out_valid_q;
  logic       drawn_q;
  logic [8:0] dots_q;
  logic [3:0] fg_q, bg_q;
  logic       status_q;

  mtcr_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  mtcr_attr_decode u_dec (
    .cfg_i          (cfg),
    .action_i,
    .char_code_i,
    .attribute_i,
    .row_i,
    .cell_address_i,
    .blink_fast_i,
    .blink_slow_i,
    .in_display_i,
    .ctrl_o         (ctrl_dec)
  );

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign accept     = in_valid_i & in_ready_o;

  assign mem_we = accept & ~action_i
                  & ({1'b0, font_address_i} < 14'(FONT_DEPTH));
  assign mem_re = accept & ctrl_dec.drawn;
  assign mem_addr = action_i ? FontAw'({row_i[3], char_code_i, row_i[2:0]})
                             : font_address_i[FontAw-1:0];

  mtcr_font_mem u_font (
    .clk_i,
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (font_data_i),
    .rdata_o (glyph)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_dec;
    end
  end

  mtcr_dot_gen u_dots (
    .ctrl_i     (ctrl_q),
    .glyph_i    (glyph),
    .last_dot_i (last_dot_q),
    .dots_o     (dots_d),
    .last_dot_o (last_dot_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_dot_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        last_dot_q  <= last_dot_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      drawn_q  <= ctrl_q.drawn;
      dots_q   <= dots_d;
      fg_q     <= ctrl_q.drawn ? ctrl_q.fg_index : 4'h0;
      bg_q     <= ctrl_q.drawn ? ctrl_q.bg_index : 4'h0;
      status_q <= last_dot_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drawn_o      = drawn_q;
  assign dots_o       = dots_q;
  assign fg_index_o   = fg_q;
  assign bg_index_o   = bg_q;
  assign status_dot_o = status_q;

endmodule
